/* design/rhpm_pkg.sv */
`default_nettype none

package rhpm_pkg;

    // Default sizes handed to the top level
    localparam int DEF_MAX_PATTERN   = 16;
    localparam int DEF_POSITION_BITS = 32;

    // Pattern register file holds sixteen bytes
    localparam int PATTERN_REG_BYTES = 16;

    // Width of the pattern length register and of the step counter
    localparam int LEN_BITS = 5;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PATTERN_LEN  = 2'd2;

    // Controller states: run the stream, or rebuild the hashes after a write
    typedef enum logic {
        ST_RUN,
        ST_CALC
    } rhpm_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic                calc_init;
        logic                calc_step;
        logic [LEN_BITS-1:0] calc_index;
        logic                shift;
        logic                eval;
        logic                eval_last;
    } rhpm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [LEN_BITS-1:0] eff_len;
        logic                eval_hit;
    } rhpm_sts_t;

    // Multiply by the hash base 131 = 128 + 2 + 1, modulo 2^64
    function automatic logic [63:0] mul_base(input logic [63:0] x);
        return (x << 7) + (x << 1) + x;
    endfunction

    // Select pattern byte k from the packed sixteen-byte pattern
    function automatic logic [7:0] pat_byte(input logic [127:0] pat, input logic [3:0] k);
        return pat[k*8 +: 8];
    endfunction

endpackage

`default_nettype wire

/* design/rhpm_ctrl.sv */
`default_nettype none

module rhpm_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire                  in_valid,
    input  wire                  in_last,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  rhpm_pkg::rhpm_sts_t  sts,
    output rhpm_pkg::rhpm_cmd_t  cmd
);
    import rhpm_pkg::*;

    rhpm_state_t         state_reg, state_next;
    logic [LEN_BITS-1:0] calc_cnt_reg, calc_cnt_next;
    logic                eval_pend_reg, eval_pend_next;
    logic                eval_last_reg, eval_last_next;
    logic                out_valid_reg, out_valid_next;

    logic                eval_fire;
    logic                accept;
    logic                calc_last;

    // Evaluate the pending item once the output register can take its result
    assign eval_fire = eval_pend_reg && (!out_valid_reg || out_ready);
    assign calc_last = (calc_cnt_reg == (sts.eff_len - LEN_BITS'(1)));

    // Take a byte in run state unless an evaluation is stuck or ends a text
    assign in_ready  = (state_reg == ST_RUN)
                       && (!eval_pend_reg || (eval_fire && !eval_last_reg));
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (cfg_we)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (!cfg_we && calc_last)
                    state_next = ST_RUN;
            end
            default:
                state_next = ST_RUN;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd            = '0;
        cmd.calc_init  = cfg_we;
        cmd.calc_step  = (state_reg == ST_CALC) && !cfg_we;
        cmd.calc_index = calc_cnt_reg;
        cmd.shift      = accept;
        cmd.eval       = eval_fire;
        cmd.eval_last  = eval_last_reg;
    end

    // Step counter, pending evaluation and output valid
    always_comb
    begin
        calc_cnt_next  = calc_cnt_reg;
        eval_pend_next = eval_pend_reg;
        eval_last_next = eval_last_reg;
        out_valid_next = out_valid_reg;

        priority if (cfg_we)
            calc_cnt_next = '0;
        else if (state_reg == ST_CALC)
            calc_cnt_next = calc_cnt_reg + LEN_BITS'(1);
        else
            calc_cnt_next = calc_cnt_reg;

        priority if (accept)
        begin
            eval_pend_next = 1'b1;
            eval_last_next = in_last;
        end
        else if (eval_fire)
            eval_pend_next = 1'b0;
        else
            eval_pend_next = eval_pend_reg;

        priority if (eval_fire && (sts.eval_hit || eval_last_reg))
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            calc_cnt_reg  <= '0;
            eval_pend_reg <= 1'b0;
            eval_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            calc_cnt_reg  <= calc_cnt_next;
            eval_pend_reg <= eval_pend_next;
            eval_last_reg <= eval_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // No byte enters while the hashes are being rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> !accept)
        else $error("byte accepted during hash rebuild");

    // The step counter never runs past the pattern length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (calc_cnt_reg < sts.eff_len))
        else $error("rebuild counter past pattern length");

    // A text's last byte is evaluated before the next text begins
    assert property (@(posedge clk) disable iff (!rst_n)
        (eval_pend_reg && eval_last_reg) |-> !accept)
        else $error("byte accepted before end of text was evaluated");

    // A result only appears after an evaluation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(eval_pend_reg))
        else $error("result raised without an evaluated byte");
`endif

endmodule

`default_nettype wire

/* design/rhpm_datapath.sv */
`default_nettype none

module rhpm_datapath #(
    parameter int MAX_PATTERN   = rhpm_pkg::DEF_MAX_PATTERN,
    parameter int POSITION_BITS = rhpm_pkg::DEF_POSITION_BITS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [rhpm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire  [rhpm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire  [7:0]                          in_data,
    input  rhpm_pkg::rhpm_cmd_t                 cmd,
    output rhpm_pkg::rhpm_sts_t                 sts,
    output logic                                out_match_valid,
    output logic [31:0]                         out_match_start,
    output logic                                out_text_done
);
    import rhpm_pkg::*;

    localparam int CAP      = (MAX_PATTERN < PATTERN_REG_BYTES) ? MAX_PATTERN
                                                                : PATTERN_REG_BYTES;
    localparam int IDX_BITS = (CAP > 1) ? $clog2(CAP) : 1;

    // Configuration registers
    logic [63:0]            pat_low_reg, pat_low_next;
    logic [63:0]            pat_high_reg, pat_high_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;

    // Text state and hashes
    logic [7:0]             window_reg [CAP];
    logic [7:0]             window_next [CAP];
    logic [7:0]             aligned_reg [CAP];
    logic [7:0]             aligned_next [CAP];
    logic [63:0]            wh_reg, wh_next;
    logic [63:0]            ph_reg, ph_next;
    logic [63:0]            lp_reg, lp_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    // Evaluation and result registers
    logic [POSITION_BITS-1:0] eval_idx_reg;
    logic                   match_valid_reg;
    logic [31:0]            match_start_reg;
    logic                   text_done_reg;

    logic [127:0]           pattern;
    logic [LEN_BITS-1:0]    eff_len;
    logic [LEN_BITS-1:0]    tap_sel;
    logic [IDX_BITS-1:0]    tap_addr;
    logic [7:0]             tap_byte;
    logic [7:0]             pb;
    logic [63:0]            drop_term;
    logic [63:0]            roll_hash;
    logic                   bytes_eq;
    logic                   idx_ok;
    logic                   hit;
    logic [POSITION_BITS-1:0] start;
    logic [63:0]            start_wide;
    logic [31:0]            start_sat;

    assign pattern = {pat_high_reg, pat_low_reg};

    // Clamp the pattern length into 1 to CAP
    always_comb
    begin
        priority if (len_reg == '0)
            eff_len = LEN_BITS'(1);
        else if (len_reg > LEN_BITS'(CAP))
            eff_len = LEN_BITS'(CAP);
        else
            eff_len = len_reg;
    end

    // One window tap: oldest byte while streaming, byte n-1-k while rebuilding
    assign tap_sel  = cmd.calc_step ? (eff_len - LEN_BITS'(1) - cmd.calc_index)
                                    : (eff_len - LEN_BITS'(1));
    assign tap_addr = tap_sel[IDX_BITS-1:0];
    assign tap_byte = window_reg[tap_addr];
    assign pb       = pat_byte(pattern, cmd.calc_index[3:0]);

    // Roll the hash: drop the oldest byte, shift in the new one
    assign drop_term = lp_reg * 64'(tap_byte);
    assign roll_hash = mul_base(wh_reg - drop_term) + 64'(in_data);

    // Exact compare of the window with the length-aligned pattern
    always_comb
    begin
        bytes_eq = 1'b1;
        for (int j = 0; j < CAP; j++)
        begin
            if ((LEN_BITS'(j) < eff_len) && (window_reg[j] != aligned_reg[j]))
                bytes_eq = 1'b0;
        end
    end

    assign idx_ok     = (64'(eval_idx_reg) >= (64'(eff_len) - 64'd1));
    assign hit        = idx_ok && (wh_reg == ph_reg) && bytes_eq;
    assign start      = eval_idx_reg - POSITION_BITS'(eff_len - LEN_BITS'(1));
    assign start_wide = 64'(start);
    assign start_sat  = (start_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : start_wide[31:0];

    assign sts.eff_len  = eff_len;
    assign sts.eval_hit = hit;

    // Configuration writes
    always_comb
    begin
        pat_low_next  = pat_low_reg;
        pat_high_next = pat_high_reg;
        len_next      = len_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:  pat_low_next  = cfg_data;
                CFG_PATTERN_HIGH: pat_high_next = cfg_data;
                CFG_PATTERN_LEN:  len_next      = cfg_data[LEN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Hash rebuild steps, stream shift and end-of-text clear
    always_comb
    begin
        window_next  = window_reg;
        aligned_next = aligned_reg;
        wh_next      = wh_reg;
        ph_next      = ph_reg;
        lp_next      = lp_reg;
        pos_next     = pos_reg;

        priority if (cmd.calc_init)
        begin
            wh_next = '0;
            ph_next = '0;
            lp_next = 64'd1;
        end
        else if (cmd.calc_step)
        begin
            ph_next = mul_base(ph_reg) + 64'(pb);
            wh_next = mul_base(wh_reg) + 64'(tap_byte);
            if (cmd.calc_index != '0)
                lp_next = mul_base(lp_reg);
            aligned_next[tap_addr] = pb;
        end
        else if (cmd.shift)
        begin
            wh_next = roll_hash;
            for (int i = CAP - 1; i > 0; i--)
                window_next[i] = window_reg[i-1];
            window_next[0] = in_data;
            if (pos_reg != '1)
                pos_next = pos_reg + POSITION_BITS'(1);
        end
        else if (cmd.eval && cmd.eval_last)
        begin
            for (int i = 0; i < CAP; i++)
                window_next[i] = '0;
            wh_next  = '0;
            pos_next = '0;
        end
        else
        begin
            // hold window, hashes and position
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= LEN_BITS'(1);
            for (int i = 0; i < CAP; i++)
            begin
                window_reg[i]  <= '0;
                aligned_reg[i] <= '0;
            end
            wh_reg  <= '0;
            ph_reg  <= '0;
            lp_reg  <= 64'd1;
            pos_reg <= '0;
        end
        else
        begin
            pat_low_reg  <= pat_low_next;
            pat_high_reg <= pat_high_next;
            len_reg      <= len_next;
            window_reg   <= window_next;
            aligned_reg  <= aligned_next;
            wh_reg       <= wh_next;
            ph_reg       <= ph_next;
            lp_reg       <= lp_next;
            pos_reg      <= pos_next;
        end
    end

    // Hold the byte index for evaluation; load the result on evaluation
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
            eval_idx_reg <= pos_reg;
        if (cmd.eval)
        begin
            match_valid_reg <= hit;
            match_start_reg <= hit ? start_sat : 32'd0;
            text_done_reg   <= cmd.eval_last;
        end
    end

    assign out_match_valid = match_valid_reg;
    assign out_match_start = match_start_reg;
    assign out_text_done   = text_done_reg;

endmodule

`default_nettype wire

/* design/rolling_hash_pattern_matcher.sv */
// Channel     | Direction | Signals                   | Contents
// ------------+-----------+---------------------------+---------------------------------
// text in     | in        | s_axis_t{valid,ready,..}  | tdata: text_byte; tlast: last_byte
// match out   | out       | m_axis_t{valid,ready,..}  | tdata: match_start; tuser: match_valid;
//             |           |                           | tlast: text_done
// config      | in        | cfg_we, cfg_index, cfg_data | pattern low, pattern high, length
//
// One text byte per cycle unless stalled; each byte is hashed on acceptance and checked once
// the output register is free. After a tlast byte, input pauses until window and position clear.
// Each config write starts a hash rebuild of n steps (n = clamped pattern length), one base-131
// multiply-add step per cycle, with s_axis_tready low throughout.
// rst_n is asynchronous, active low; it loads an all-zero pattern of length one.
// With m_axis_tready low a result holds in the output register; input stalls after one more byte.
`default_nettype none

module rolling_hash_pattern_matcher #(
    parameter int MAX_PATTERN   = rhpm_pkg::DEF_MAX_PATTERN,
    parameter int POSITION_BITS = rhpm_pkg::DEF_POSITION_BITS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [rhpm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire  [rhpm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [7:0]                          s_axis_tdata,   // [7:0] text_byte
    input  wire                                 s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [31:0]                         m_axis_tdata,   // [31:0] match_start
    output logic [0:0]                          m_axis_tuser,   // [0] match_valid
    output logic                                m_axis_tlast
);
    import rhpm_pkg::*;

    rhpm_cmd_t cmd;
    rhpm_sts_t sts;
    logic      match_valid;

    // Sequence rebuilds, acceptance and result handoff
    rhpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Hold the window, hashes and result registers
    rhpm_datapath #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_data         (s_axis_tdata),
        .cmd             (cmd),
        .sts             (sts),
        .out_match_valid (match_valid),
        .out_match_start (m_axis_tdata),
        .out_text_done   (m_axis_tlast)
    );

    assign m_axis_tuser[0] = match_valid;

endmodule

`default_nettype wire
